/* sv/pkhd_pkg.sv */
package pkhd_pkg;

  // default sizes
  localparam int MAX_LEVELS_DEF   = 24;
  localparam int SYMBOL_SLOTS_DEF = 256;

  // threshold entries hold children counts of up to 8191
  localparam int THR_W = 13;
  localparam int CH_W  = 14;

  // magic bytes
  localparam logic [7:0] MAGIC1 = 8'h1f;
  localparam logic [7:0] MAGIC2 = 8'h1e;

  // result kinds
  localparam logic [1:0] KIND_SYM = 2'd0;
  localparam logic [1:0] KIND_END = 2'd1;
  localparam logic [1:0] KIND_ERR = 2'd2;

  // error codes
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_MAGIC    = 3'd1;
  localparam logic [2:0] ERR_LEVELS   = 3'd2;
  localparam logic [2:0] ERR_OVERFLOW = 3'd3;
  localparam logic [2:0] ERR_LENGTH   = 3'd4;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] symbol;
    logic [2:0] error_code;
    logic       last;
  } res_t;

endpackage

/* sv/pkhd_if.sv */
interface pkhd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface pkhd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] symbol;
  logic [2:0] error_code;
  logic       last;

  modport source (output valid, output kind, output symbol, output error_code,
                  output last, input ready);
  modport sink (input valid, input kind, input symbol, input error_code,
                input last, output ready);
endinterface

/* sv/pkhd_ram.sv */
module pkhd_ram #(
  parameter int W = 8,
  parameter int D = 16,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  // one write port, registered read that holds without a read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/pack_huffman_stream_decoder.sv */
// Header bytes are taken one at a time in ST_IN; the level walk after the counts
// passes ST_ENTER and ST_ECHK per level, and the threshold build after the end
// symbol ST_BTRD and ST_BTWR per level. A data byte is accepted in ST_IN, then
// each code bit passes ST_BIT (threshold/base read) and ST_CMP (compare), each
// decoded symbol ST_SYM (symbol read), and ST_FLUSH flushes a pending last beat.
// Synchronous reset returns to the first magic byte; tables undefined until written.
module pack_huffman_stream_decoder #(
  parameter int MAX_LEVELS   = pkhd_pkg::MAX_LEVELS_DEF,
  parameter int SYMBOL_SLOTS = pkhd_pkg::SYMBOL_SLOTS_DEF
) (
  input logic         clk,
  input logic         rst,
  pkhd_in_if.sink     in_ch,
  pkhd_out_if.source  out_ch
);

  localparam int LAW   = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int LV_W  = $clog2(MAX_LEVELS + 1);
  localparam int SAW   = $clog2(SYMBOL_SLOTS + 1);
  localparam int EI_W  = $clog2(SYMBOL_SLOTS + 2);
  localparam int ACC_W = MAX_LEVELS;
  localparam int LF_W  = ACC_W + 1;
  localparam int THR_W = pkhd_pkg::THR_W;
  localparam int CH_W  = pkhd_pkg::CH_W;

  typedef enum logic [3:0] {
    PH_MAGIC1, PH_MAGIC2, PH_LENGTH, PH_LEVELS, PH_COUNTS,
    PH_SYMBOLS, PH_ENDSYM, PH_DATA, PH_DONE, PH_ERROR
  } phase_t;

  typedef enum logic [3:0] {
    ST_IN, ST_ENTER, ST_ECHK, ST_BTRD, ST_BTWR, ST_BIT, ST_CMP, ST_SYM, ST_FLUSH
  } state_t;

  phase_t            phase;
  state_t            state;
  logic [8:0]        hbc;
  logic [31:0]       remlen;
  logic [LV_W-1:0]   lt;
  logic [EI_W-1:0]   end_index;
  logic [LV_W-1:0]   cl;
  logic [ACC_W-1:0]  acc;
  logic [THR_W-1:0]  cur_thr;
  logic [LV_W-1:0]   bi;
  logic              bt_first;
  logic [CH_W-1:0]   children;
  logic [7:0]        dbyte;
  logic [2:0]        bitn;
  logic              pend_valid;
  pkhd_pkg::res_t    pend;
  logic              out_valid;
  pkhd_pkg::res_t    out_r;

  // memories
  logic              thr_we, thr_re, base_we, bs_re, sym_we, sym_re;
  logic [LAW-1:0]    thr_waddr, thr_raddr, base_waddr;
  logic [THR_W-1:0]  thr_wdata, thr_rdata;
  logic [EI_W-1:0]   base_rdata;
  logic [SAW-1:0]    sym_waddr, sym_raddr;
  logic [7:0]        sym_rdata;

  pkhd_ram #(.W(THR_W), .D(MAX_LEVELS)) u_thr (
    .clk, .we(thr_we), .waddr(thr_waddr), .wdata(thr_wdata),
    .re(thr_re), .raddr(thr_raddr), .rdata(thr_rdata)
  );

  pkhd_ram #(.W(EI_W), .D(MAX_LEVELS)) u_base (
    .clk, .we(base_we), .waddr(base_waddr), .wdata(end_index),
    .re(bs_re), .raddr(thr_raddr), .rdata(base_rdata)
  );

  pkhd_ram #(.W(8), .D(SYMBOL_SLOTS + 1)) u_sym (
    .clk, .we(sym_we), .waddr(sym_waddr), .wdata(in_ch.in_byte),
    .re(sym_re), .raddr(sym_raddr), .rdata(sym_rdata)
  );

  logic              in_acc, out_free, can_res;
  logic              cur_bit;
  logic [ACC_W-1:0]  acc_sh;
  logic              acc_lt;
  logic [LF_W-1:0]   leaf;
  logic [CH_W-1:0]   leaves, half;

  assign in_ch.ready = (state == ST_IN) && !rst;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid || out_ch.ready;
  assign can_res     = !pend_valid || out_free;
  assign cur_bit     = dbyte[3'd7 - bitn];
  assign acc_sh      = {acc[ACC_W-2:0], cur_bit};
  assign acc_lt      = acc < ACC_W'(thr_rdata);
  assign leaf        = LF_W'(base_rdata) + (LF_W'(acc) - LF_W'(thr_rdata));
  assign leaves      = CH_W'(thr_rdata) + (bt_first ? CH_W'(2) : CH_W'(0));
  assign half        = children >> 1;

  // memory address and strobe selection
  always_comb begin
    thr_we    = 1'b0;
    thr_waddr = hbc[LAW-1:0];
    thr_wdata = THR_W'(in_ch.in_byte);
    thr_re    = 1'b0;
    bs_re     = 1'b0;
    thr_raddr = cl[LAW-1:0];
    base_we   = 1'b0;
    base_waddr = cl[LAW-1:0];
    sym_we    = 1'b0;
    sym_waddr = end_index[SAW-1:0];
    sym_re    = 1'b0;
    sym_raddr = leaf[SAW-1:0];
    unique case (state)
      ST_IN: begin
        thr_we = in_acc && (phase == PH_COUNTS);
        sym_we = in_acc &&
                 (((phase == PH_SYMBOLS) && (end_index < EI_W'(SYMBOL_SLOTS))) ||
                  ((phase == PH_ENDSYM) && (end_index <= EI_W'(SYMBOL_SLOTS))));
      end
      ST_ENTER: begin
        thr_re  = cl < lt;
        base_we = cl < lt;
      end
      ST_BTRD: begin
        thr_re    = 1'b1;
        thr_raddr = LAW'(bi - LV_W'(1));
      end
      ST_BTWR: begin
        thr_we    = 1'b1;
        thr_waddr = LAW'(bi - LV_W'(1));
        thr_wdata = THR_W'(half);
      end
      ST_BIT: begin
        thr_raddr = cl[LAW-1:0];
        thr_re    = cl < lt;
        bs_re     = cl < lt;
      end
      ST_CMP: begin
        sym_re = !acc_lt && (leaf < LF_W'(end_index));
      end
      default: begin
      end
    endcase
  end

  // control, pending result and output register
  always_ff @(posedge clk) begin : ctl
    logic           emit;
    pkhd_pkg::res_t er;
    emit = 1'b0;
    er   = '0;
    if (rst) begin
      phase      <= PH_MAGIC1;
      state      <= ST_IN;
      hbc        <= '0;
      remlen     <= '0;
      lt         <= '0;
      end_index  <= '0;
      cl         <= LV_W'(1);
      acc        <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IN: begin
          if (in_acc) begin
            unique case (phase)
              PH_MAGIC1: begin
                if (in_ch.in_byte != pkhd_pkg::MAGIC1) begin
                  emit = 1'b1;
                  er = '{pkhd_pkg::KIND_ERR, 8'd0, pkhd_pkg::ERR_MAGIC, 1'b1};
                end else begin
                  phase <= PH_MAGIC2;
                end
              end
              PH_MAGIC2: begin
                if (in_ch.in_byte != pkhd_pkg::MAGIC2) begin
                  emit = 1'b1;
                  er = '{pkhd_pkg::KIND_ERR, 8'd0, pkhd_pkg::ERR_MAGIC, 1'b1};
                end else begin
                  phase <= PH_LENGTH;
                  hbc   <= '0;
                end
              end
              PH_LENGTH: begin
                remlen <= {remlen[23:0], in_ch.in_byte};
                hbc    <= hbc + 9'd1;
                if (hbc + 9'd1 >= 9'd4) begin
                  phase <= PH_LEVELS;
                end
              end
              PH_LEVELS: begin
                if (in_ch.in_byte == 8'd0 || in_ch.in_byte > 8'(MAX_LEVELS)) begin
                  emit = 1'b1;
                  er = '{pkhd_pkg::KIND_ERR, 8'd0, pkhd_pkg::ERR_LEVELS, 1'b1};
                end else begin
                  lt    <= LV_W'(in_ch.in_byte);
                  hbc   <= '0;
                  phase <= PH_COUNTS;
                end
              end
              PH_COUNTS: begin
                hbc <= hbc + 9'd1;
                if (hbc + 9'd1 >= 9'(lt)) begin
                  hbc   <= '0;
                  cl    <= '0;
                  phase <= PH_SYMBOLS;
                  state <= ST_ENTER;
                end
              end
              PH_SYMBOLS: begin
                if (end_index >= EI_W'(SYMBOL_SLOTS)) begin
                  emit = 1'b1;
                  er = '{pkhd_pkg::KIND_ERR, 8'd0, pkhd_pkg::ERR_OVERFLOW, 1'b1};
                end else begin
                  end_index <= end_index + EI_W'(1);
                  hbc       <= hbc + 9'd1;
                  if (THR_W'(hbc + 9'd1) >= cur_thr) begin
                    hbc   <= '0;
                    cl    <= cl + LV_W'(1);
                    state <= ST_ENTER;
                  end
                end
              end
              PH_ENDSYM: begin
                if (end_index > EI_W'(SYMBOL_SLOTS)) begin
                  emit = 1'b1;
                  er = '{pkhd_pkg::KIND_ERR, 8'd0, pkhd_pkg::ERR_OVERFLOW, 1'b1};
                end else begin
                  end_index <= end_index + EI_W'(1);
                  bi        <= lt;
                  bt_first  <= 1'b1;
                  children  <= '0;
                  state     <= ST_BTRD;
                end
              end
              PH_DATA: begin
                dbyte <= in_ch.in_byte;
                bitn  <= '0;
                state <= ST_BIT;
              end
              default: begin
              end
            endcase
          end
        end
        // skip levels with no counted leaves
        ST_ENTER: begin
          if (cl < lt) begin
            state <= ST_ECHK;
          end else begin
            phase <= PH_ENDSYM;
            state <= ST_IN;
          end
        end
        ST_ECHK: begin
          if (thr_rdata != '0) begin
            cur_thr <= thr_rdata;
            state   <= ST_IN;
          end else begin
            cl    <= cl + LV_W'(1);
            state <= ST_ENTER;
          end
        end
        // threshold build, deepest level first
        ST_BTRD: begin
          state <= ST_BTWR;
        end
        ST_BTWR: begin
          bt_first <= 1'b0;
          children <= half + leaves;
          if (bi == LV_W'(1)) begin
            phase <= PH_DATA;
            cl    <= '0;
            acc   <= '0;
            state <= ST_IN;
          end else begin
            bi    <= bi - LV_W'(1);
            state <= ST_BTRD;
          end
        end
        // one code bit
        ST_BIT: begin
          if (cl >= lt) begin
            if (can_res) begin
              acc  <= acc_sh;
              emit = 1'b1;
              er = '{pkhd_pkg::KIND_ERR, 8'd0, pkhd_pkg::ERR_OVERFLOW, 1'b1};
            end
          end else begin
            acc   <= acc_sh;
            state <= ST_CMP;
          end
        end
        ST_CMP: begin
          if (acc_lt) begin
            cl <= cl + LV_W'(1);
            if (bitn == 3'd7) begin
              state <= pend_valid ? ST_FLUSH : ST_IN;
            end else begin
              bitn  <= bitn + 3'd1;
              state <= ST_BIT;
            end
          end else if (leaf < LF_W'(end_index)) begin
            state <= ST_SYM;
          end else if (can_res) begin
            emit = 1'b1;
            if (leaf == LF_W'(end_index) && remlen == '0) begin
              er = '{pkhd_pkg::KIND_END, 8'd0, pkhd_pkg::ERR_NONE, 1'b1};
            end else if (leaf == LF_W'(end_index)) begin
              er = '{pkhd_pkg::KIND_ERR, 8'd0, pkhd_pkg::ERR_LENGTH, 1'b1};
            end else begin
              er = '{pkhd_pkg::KIND_ERR, 8'd0, pkhd_pkg::ERR_OVERFLOW, 1'b1};
            end
          end
        end
        // decoded leaf
        ST_SYM: begin
          if (can_res) begin
            emit = 1'b1;
            er = '{pkhd_pkg::KIND_SYM, sym_rdata, pkhd_pkg::ERR_NONE, 1'b0};
            remlen <= remlen - 32'd1;
            cl     <= '0;
            acc    <= '0;
            if (bitn == 3'd7) begin
              state <= ST_FLUSH;
            end else begin
              bitn  <= bitn + 3'd1;
              state <= ST_BIT;
            end
          end
        end
        // last pending beat of this byte
        ST_FLUSH: begin
          if (out_free) begin
            out_r      <= '{pend.kind, pend.symbol, pend.error_code, 1'b1};
            out_valid  <= 1'b1;
            pend_valid <= 1'b0;
            state      <= ST_IN;
          end
        end
        default: begin
          state <= ST_IN;
        end
      endcase
      // a new result pushes the pending one out
      if (emit) begin
        if (pend_valid) begin
          out_r     <= pend;
          out_valid <= 1'b1;
        end
        pend       <= er;
        pend_valid <= 1'b1;
        if (er.last) begin
          phase <= (er.kind == pkhd_pkg::KIND_END) ? PH_DONE : PH_ERROR;
          state <= ST_FLUSH;
        end
      end
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.kind       = out_r.kind;
  assign out_ch.symbol     = out_r.symbol;
  assign out_ch.error_code = out_r.error_code;
  assign out_ch.last       = out_r.last;

endmodule

/* sv/pkhd_checker.sv */
module pkhd_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] kind,
  input logic [7:0] symbol,
  input logic [2:0] error_code,
  input logic       last
);

  // a waiting beat holds until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(symbol))
    else $error("output beat dropped or changed while stalled");

  // payload fields agree with the kind
  a_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (kind == pkhd_pkg::KIND_SYM) ? (error_code == pkhd_pkg::ERR_NONE)
                                               : (symbol == 8'd0))
    else $error("symbol or error code inconsistent with kind");

  // end and error close the byte
  a_final_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != pkhd_pkg::KIND_SYM |-> last)
    else $error("end or error beat without last");

  // nothing follows end or error
  a_silent: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && kind != pkhd_pkg::KIND_SYM |=> !out_valid)
    else $error("beat after end of stream or error");

endmodule

bind pack_huffman_stream_decoder pkhd_checker u_pkhd_checker (
  .clk(clk),
  .rst(rst),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .kind(out_ch.kind),
  .symbol(out_ch.symbol),
  .error_code(out_ch.error_code),
  .last(out_ch.last)
);

/* tb/sv/tb_top.sv */
module tb_top;

  localparam int LEVELS   = 5;
  localparam int N_LEAVES = 14;
  localparam int DATA_BYTES = 250;

  // predictor phases
  typedef enum int {
    P_MAGIC1, P_MAGIC2, P_LENGTH, P_LEVELS, P_COUNTS, P_SYMBOLS, P_ENDSYM,
    P_DATA, P_DONE, P_ERROR
  } dec_phase_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pkhd_in_if  in_ch ();
  pkhd_out_if out_ch ();

  pack_huffman_stream_decoder dut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #6 clk = ~clk;

  // predictor state
  dec_phase_t  ph;
  int unsigned hdr_cnt;
  logic [31:0] rem_len;
  int unsigned lvl_total;
  int unsigned lvl_thr [pkhd_pkg::MAX_LEVELS_DEF];
  int unsigned lvl_base [pkhd_pkg::MAX_LEVELS_DEF];
  logic [7:0]  sym_mem [pkhd_pkg::SYMBOL_SLOTS_DEF + 1];
  int unsigned end_idx;
  int unsigned cur_lvl;
  int unsigned code_acc;

  pkhd_pkg::res_t expected_results[$];
  int   mismatches = 0;
  int   tx_idle = 0;
  int   rx_idle = 0;

  // stream under test
  int unsigned leaf_cnt [1:LEVELS] = '{0, 1, 2, 4, 6};
  logic [7:0]  leaf_sym [N_LEAVES];
  int unsigned leaf_len [N_LEAVES + 1];
  int unsigned leaf_code [N_LEAVES + 1];
  bit          code_bits[$];
  int unsigned sym_total;

  task automatic enter_level_walk();
    while (cur_lvl < lvl_total && cur_lvl < pkhd_pkg::MAX_LEVELS_DEF) begin
      lvl_base[cur_lvl] = end_idx;
      if (lvl_thr[cur_lvl] != 0) return;
      cur_lvl++;
    end
    ph = P_ENDSYM;
  endtask

  // advance the decoder model by one byte and queue the results it gives
  task automatic decode_byte(input logic [7:0] b);
    pkhd_pkg::res_t outs[$];
    pkhd_pkg::res_t r;
    int unsigned    children, leaves, lvl, thr, leaf;
    outs = {};
    r = '0;
    case (ph)
      P_MAGIC1: if (b != pkhd_pkg::MAGIC1) begin
        r.kind = pkhd_pkg::KIND_ERR; r.error_code = pkhd_pkg::ERR_MAGIC;
        outs.push_back(r); ph = P_ERROR;
      end else ph = P_MAGIC2;
      P_MAGIC2: if (b != pkhd_pkg::MAGIC2) begin
        r.kind = pkhd_pkg::KIND_ERR; r.error_code = pkhd_pkg::ERR_MAGIC;
        outs.push_back(r); ph = P_ERROR;
      end else begin
        ph = P_LENGTH; hdr_cnt = 0;
      end
      P_LENGTH: begin
        rem_len = {rem_len[23:0], b};
        hdr_cnt++;
        if (hdr_cnt >= 4) ph = P_LEVELS;
      end
      P_LEVELS: if (b == 0 || 32'(b) > pkhd_pkg::MAX_LEVELS_DEF) begin
        r.kind = pkhd_pkg::KIND_ERR; r.error_code = pkhd_pkg::ERR_LEVELS;
        outs.push_back(r); ph = P_ERROR;
      end else begin
        lvl_total = 32'(b); hdr_cnt = 0; ph = P_COUNTS;
      end
      P_COUNTS: begin
        if (hdr_cnt < pkhd_pkg::MAX_LEVELS_DEF) lvl_thr[hdr_cnt] = 32'(b);
        hdr_cnt++;
        if (hdr_cnt >= lvl_total) begin
          hdr_cnt = 0; cur_lvl = 0; ph = P_SYMBOLS;
          enter_level_walk();
        end
      end
      P_SYMBOLS: if (end_idx >= pkhd_pkg::SYMBOL_SLOTS_DEF) begin
        r.kind = pkhd_pkg::KIND_ERR; r.error_code = pkhd_pkg::ERR_OVERFLOW;
        outs.push_back(r); ph = P_ERROR;
      end else begin
        sym_mem[end_idx] = b; end_idx++; hdr_cnt++;
        if (cur_lvl >= pkhd_pkg::MAX_LEVELS_DEF || hdr_cnt >= lvl_thr[cur_lvl]) begin
          hdr_cnt = 0; cur_lvl++;
          enter_level_walk();
        end
      end
      P_ENDSYM: if (end_idx > pkhd_pkg::SYMBOL_SLOTS_DEF) begin
        r.kind = pkhd_pkg::KIND_ERR; r.error_code = pkhd_pkg::ERR_OVERFLOW;
        outs.push_back(r); ph = P_ERROR;
      end else begin
        sym_mem[end_idx] = b; end_idx++;
        // leaf counts become internal-node thresholds, deepest level first
        lvl_thr[lvl_total - 1] += 2;
        children = 0;
        for (int i = lvl_total; i >= 1; i--) begin
          leaves = lvl_thr[i - 1];
          children = children / 2;
          lvl_thr[i - 1] = children;
          children += leaves;
        end
        cur_lvl = 1; code_acc = 0; ph = P_DATA;
      end
      P_DATA: begin
        for (int n = 0; n < 8; n++) begin
          lvl = cur_lvl - 1;
          code_acc = (code_acc << 1) | 32'(b[7 - n]);
          r = '0;
          if (lvl >= lvl_total || lvl >= pkhd_pkg::MAX_LEVELS_DEF) begin
            r.kind = pkhd_pkg::KIND_ERR; r.error_code = pkhd_pkg::ERR_OVERFLOW;
            outs.push_back(r);
            ph = P_ERROR; break;
          end
          thr = lvl_thr[lvl];
          if (code_acc < thr) begin
            cur_lvl++;
            continue;
          end
          leaf = lvl_base[lvl] + (code_acc - thr);
          if (leaf == end_idx) begin
            if (rem_len != 0) begin
              r.kind = pkhd_pkg::KIND_ERR; r.error_code = pkhd_pkg::ERR_LENGTH;
              ph = P_ERROR;
            end else begin
              r.kind = pkhd_pkg::KIND_END; ph = P_DONE;
            end
            outs.push_back(r);
            break;
          end
          if (leaf > end_idx || leaf > pkhd_pkg::SYMBOL_SLOTS_DEF) begin
            r.kind = pkhd_pkg::KIND_ERR; r.error_code = pkhd_pkg::ERR_OVERFLOW;
            outs.push_back(r);
            ph = P_ERROR; break;
          end
          r.kind = pkhd_pkg::KIND_SYM; r.symbol = sym_mem[leaf];
          outs.push_back(r);
          rem_len--;
          cur_lvl = 1; code_acc = 0;
        end
      end
      default: ;
    endcase
    if (outs.size() > 0) outs[outs.size() - 1].last = 1'b1;
    foreach (outs[i]) expected_results.push_back(outs[i]);
  endtask

  // send one beat on the input channel, called at a falling edge
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < tx_idle) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid   = 1'b1;
    in_ch.in_byte = b;
    do @(posedge clk); while (!in_ch.ready);
    decode_byte(b);
    @(negedge clk);
    in_ch.valid   = 1'b0;
    in_ch.in_byte = 8'($urandom_range(255));
  endtask

  task automatic wait_drained();
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  // build canonical codes for the chosen table and a random symbol stream
  task automatic build_stream();
    int unsigned thr_of [1:LEVELS];
    int unsigned children, per_lvl, idx, pick;
    children = 0;
    for (int l = LEVELS; l >= 1; l--) begin
      per_lvl = leaf_cnt[l] + ((l == LEVELS) ? 2 : 0);
      children = children / 2;
      thr_of[l] = children;
      children += per_lvl;
    end
    idx = 0;
    for (int l = 1; l <= LEVELS; l++) begin
      per_lvl = leaf_cnt[l] + ((l == LEVELS) ? 2 : 0);
      for (int j = 0; j < per_lvl; j++) begin
        leaf_len[idx]  = l;
        leaf_code[idx] = thr_of[l] + j;
        idx++;
      end
    end
    foreach (leaf_sym[i]) leaf_sym[i] = 8'($urandom_range(255));
    leaf_sym[0] = 8'h00;
    leaf_sym[1] = 8'hff;
    code_bits = {};
    sym_total = 0;
    while (code_bits.size() < 8 * DATA_BYTES) begin
      pick = $urandom_range(N_LEAVES - 1);
      for (int k = leaf_len[pick] - 1; k >= 0; k--) code_bits.push_back(leaf_code[pick][k]);
      sym_total++;
    end
    // end-of-stream leaf, then random padding bits
    for (int k = leaf_len[N_LEAVES] - 1; k >= 0; k--)
      code_bits.push_back(leaf_code[N_LEAVES][k]);
    while (code_bits.size() % 8 != 0) code_bits.push_back(1'($urandom_range(1)));
  endtask

  // magic, length, level count, leaf counts, leaf symbols
  task automatic test_header();
    logic [31:0] len;
    len = sym_total;
    send_byte(pkhd_pkg::MAGIC1);
    send_byte(pkhd_pkg::MAGIC2);
    for (int i = 3; i >= 0; i--) send_byte(len[8 * i +: 8]);
    send_byte(8'(LEVELS));
    for (int l = 1; l <= LEVELS; l++) send_byte(8'(leaf_cnt[l]));
    foreach (leaf_sym[i]) send_byte(leaf_sym[i]);
  endtask

  // code bytes under three idle patterns, with one full drain in the middle
  task automatic test_data();
    logic [7:0] b;
    int nbytes;
    nbytes = code_bits.size() / 8;
    for (int i = 0; i < nbytes; i++) begin
      if (i == nbytes / 3) begin
        tx_idle = 87; rx_idle = 32;
      end else if (i == 2 * nbytes / 3) begin
        tx_idle = 0; rx_idle = 0;
      end
      if (i == nbytes / 2) wait_drained();
      for (int k = 0; k < 8; k++) b[7 - k] = code_bits[8 * i + k];
      send_byte(b);
    end
  endtask

  // bytes after the end leaf give no results
  task automatic test_after_end();
    for (int i = 0; i < 6; i++) send_byte(8'($urandom_range(255)));
  endtask

  // receiver stalls
  always @(negedge clk) out_ch.ready <= ($urandom_range(99) >= rx_idle);

  // result checker
  always @(posedge clk) begin
    pkhd_pkg::res_t exp_r, got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.kind, out_ch.symbol, out_ch.error_code, out_ch.last};
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        mismatches++;
      end else begin
        exp_r = expected_results.pop_front();
        if (got !== exp_r) begin
          $display("%0t: result mismatch, expected kind %0d sym %h err %0d last %0b,",
                   $time, exp_r.kind, exp_r.symbol, exp_r.error_code, exp_r.last);
          $display("%0t:   actual kind %0d sym %h err %0d last %0b",
                   $time, got.kind, got.symbol, got.error_code, got.last);
          mismatches++;
        end
      end
    end
  end

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.in_byte = 8'h00;
    out_ch.ready  = 1'b0;
    ph = P_MAGIC1; hdr_cnt = 0; rem_len = '0; lvl_total = 0;
    foreach (lvl_thr[i]) begin
      lvl_thr[i] = 0; lvl_base[i] = 0;
    end
    foreach (sym_mem[i]) sym_mem[i] = '0;
    end_idx = 0; cur_lvl = 1; code_acc = 0;
    build_stream();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    tx_idle = 32; rx_idle = 87;
    test_header();
    test_data();
    test_after_end();
    wait_drained();
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

/* filelist.f */
sv/pkhd_pkg.sv
sv/pkhd_if.sv
sv/pkhd_ram.sv
sv/pack_huffman_stream_decoder.sv
sv/pkhd_checker.sv
tb/sv/tb_top.sv
